/* design/rbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared constants for the ROM/RAM bank mapper: field widths, access kinds,
// result status codes and the cartridge RAM geometry.
// ----------------------------------------------------------------------------
package rbm_pkg;

    // Bus and result field widths.
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int ROM_ADDR_W = 21;
    localparam int STATUS_W   = 2;

    // Bank register widths.
    localparam int ROM_BANK_W = 7;
    localparam int RAM_BANK_W = 2;

    // Memory geometry.
    localparam int ROM_BANK_BYTES  = 16384;
    localparam int ROM_OFFSET_W    = $clog2(ROM_BANK_BYTES);
    localparam int RAM_BANK_BYTES  = 8192;
    localparam int RAM_OFFSET_W    = $clog2(RAM_BANK_BYTES);
    localparam int RAM_BANKS_DFLT  = 4;
    localparam int RAM_FULL_IDX_W  = RAM_BANK_W + RAM_OFFSET_W;

    // Access kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ROM_READ = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RAM_READ = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WRITE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ILLEGAL  = 2'd3;

    // Reset value of the ROM bank register.
    localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 7'd1;

endpackage : rbm_pkg
`default_nettype wire

/* design/rbm_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbm_req_if
// Request channel of the bank mapper: one bus access per item.
// ----------------------------------------------------------------------------
interface rbm_req_if;

    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [rbm_pkg::ADDR_W-1:0]  address;
    logic [rbm_pkg::DATA_W-1:0]  write_data;

    modport source (output valid, output kind, output address, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input address, input write_data,
                    output ready);

endinterface : rbm_req_if
`default_nettype wire

/* design/rbm_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbm_rsp_if
// Response channel of the bank mapper: one result item per access.
// ----------------------------------------------------------------------------
interface rbm_rsp_if;

    logic                           valid;
    logic                           ready;
    logic [rbm_pkg::STATUS_W-1:0]   status;
    logic [rbm_pkg::ROM_ADDR_W-1:0] rom_address;
    logic [rbm_pkg::DATA_W-1:0]     read_data;

    modport source (output valid, output status, output rom_address, output read_data,
                    input ready);
    modport sink   (input valid, input status, input rom_address, input read_data,
                    output ready);

endinterface : rbm_rsp_if
`default_nettype wire

/* design/rbm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbm_ram
// Generic single-port synchronous RAM. A read is issued with en high and we
// low; its data appears on rdata in the cycle after and holds until the next read.
// ----------------------------------------------------------------------------
module rbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port share the address.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule : rbm_ram
`default_nettype wire

/* design/rom_ram_bank_mapper_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_top
// Cartridge bank controller: maps ROM reads to physical addresses, serves the
// banked cartridge RAM and holds the ROM bank, RAM bank and mode registers.
// ----------------------------------------------------------------------------
// The mapper takes one bus access per clock cycle while the response side does
// not stall it, and gives one result item for each, in order, through the read
// stage and then the output register. The single port of the cartridge RAM is
// used at most once per access, and its registered read data sets the depth of
// the pipe: a read stage that waits for the RAM data, then an output register.
// Bank and mode writes take effect at the edge that accepts them, so the next
// access already sees them. The cartridge RAM is not cleared at reset; a RAM
// byte must be written before it is read.
// ----------------------------------------------------------------------------
module rom_ram_bank_mapper_top #(
    parameter int RAM_BANKS = rbm_pkg::RAM_BANKS_DFLT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rbm_req_if.sink    req,
    rbm_rsp_if.source  rsp
);

    localparam int RAM_DEPTH = RAM_BANKS * rbm_pkg::RAM_BANK_BYTES;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    // Bank and mode registers.
    logic [rbm_pkg::ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [rbm_pkg::RAM_BANK_W-1:0] ram_bank_reg, ram_bank_next;
    logic                           ram_mode_reg, ram_mode_next;

    // Read stage (waits for RAM data) and output register.
    logic                              s1_valid_reg, s1_valid_next;
    logic [rbm_pkg::STATUS_W-1:0]      s1_status_reg, s1_status_next;
    logic [rbm_pkg::ROM_ADDR_W-1:0]    s1_rom_address_reg, s1_rom_address_next;
    logic                              out_valid_reg, out_valid_next;
    logic [rbm_pkg::STATUS_W-1:0]      out_status_reg;
    logic [rbm_pkg::ROM_ADDR_W-1:0]    out_rom_address_reg;
    logic [rbm_pkg::DATA_W-1:0]        out_read_data_reg;

    logic                              accept;
    logic                              s1_move;
    logic                              in_ram_window;
    logic [rbm_pkg::RAM_BANK_W-1:0]    bank_mod;
    logic [rbm_pkg::RAM_FULL_IDX_W-1:0] ram_full_index;
    logic [RAM_AW-1:0]                 ram_index;
    logic                              ram_en;
    logic                              ram_we;
    logic [rbm_pkg::DATA_W-1:0]        ram_rdata;

    // Apply the bank fix-up: a bank whose low five bits are zero moves up by one.
    function automatic logic [rbm_pkg::ROM_BANK_W-1:0] fix_bank(
        input logic [rbm_pkg::ROM_BANK_W-1:0] bank
    );
        logic [rbm_pkg::ROM_BANK_W-1:0] res;
        res = bank;
        if (bank[4:0] == 5'd0)
        begin
            res = bank + 7'd1;
        end
        return res;
    endfunction

    // Handshake: the read stage advances when the output register is free or being read out.
    assign s1_move   = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_move;
    assign accept    = req.valid && req.ready;

    // Cartridge RAM address: bank wrapped to the banks present, then offset.
    assign in_ram_window = (req.address inside {[16'hA000:16'hBFFF]});

    always_comb
    begin
        if (RAM_BANKS == 1)
        begin
            bank_mod = '0;
        end
        else if ({1'b0, ram_bank_reg} >= 3'(RAM_BANKS))
        begin
            bank_mod = 2'({1'b0, ram_bank_reg} - 3'(RAM_BANKS));
        end
        else
        begin
            bank_mod = ram_bank_reg;
        end
    end

    assign ram_full_index = {bank_mod, req.address[rbm_pkg::RAM_OFFSET_W-1:0]};
    assign ram_index      = ram_full_index[RAM_AW-1:0];
    assign ram_en         = accept && in_ram_window;
    assign ram_we         = (req.kind == rbm_pkg::KIND_WRITE);

    rbm_ram #(
        .WIDTH (rbm_pkg::DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_cart_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_index),
        .wdata (req.write_data),
        .rdata (ram_rdata)
    );

    // Register writes and read decode for the accepted access.
    always_comb
    begin
        rom_bank_next       = rom_bank_reg;
        ram_bank_next       = ram_bank_reg;
        ram_mode_next       = ram_mode_reg;
        s1_status_next      = rbm_pkg::ST_ILLEGAL;
        s1_rom_address_next = '0;
        if (req.kind == rbm_pkg::KIND_WRITE)
        begin
            s1_status_next = rbm_pkg::ST_WRITE;
            if (req.address inside {[16'h2000:16'h3FFF]})
            begin
                rom_bank_next = fix_bank({rom_bank_reg[6:5], req.write_data[4:0]});
            end
            else if (req.address inside {[16'h4000:16'h5FFF]})
            begin
                if (ram_mode_reg)
                begin
                    ram_bank_next = req.write_data[1:0];
                end
                else
                begin
                    rom_bank_next = fix_bank({req.write_data[1:0], rom_bank_reg[4:0]});
                end
            end
            else if (req.address inside {[16'h6000:16'h7FFF]})
            begin
                ram_mode_next = req.write_data[0];
            end
        end
        else
        begin
            if (req.address inside {[16'h0000:16'h3FFF]})
            begin
                s1_status_next      = rbm_pkg::ST_ROM_READ;
                s1_rom_address_next = {5'd0, req.address};
            end
            else if (req.address inside {[16'h4000:16'h7FFF]})
            begin
                s1_status_next      = rbm_pkg::ST_ROM_READ;
                s1_rom_address_next = {rom_bank_reg,
                                       req.address[rbm_pkg::ROM_OFFSET_W-1:0]};
            end
            else if (in_ram_window)
            begin
                s1_status_next = rbm_pkg::ST_RAM_READ;
            end
        end
    end

    // Valid flags of the two stages.
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg  <= rbm_pkg::ROM_BANK_RESET;
            ram_bank_reg  <= '0;
            ram_mode_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                rom_bank_reg <= rom_bank_next;
                ram_bank_reg <= ram_bank_next;
                ram_mode_reg <= ram_mode_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the read stage and the output register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg      <= s1_status_next;
            s1_rom_address_reg <= s1_rom_address_next;
        end
        if (s1_move && s1_valid_reg)
        begin
            out_status_reg      <= s1_status_reg;
            out_rom_address_reg <= s1_rom_address_reg;
            out_read_data_reg   <= (s1_status_reg == rbm_pkg::ST_RAM_READ) ? ram_rdata : '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.rom_address = out_rom_address_reg;
    assign rsp.read_data   = out_read_data_reg;

    // An accepted access always occupies the read stage in the next cycle.
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted access did not reach the read stage");

    // The ROM bank register never holds a bank with zero low bits.
    a_rom_bank_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        rom_bank_reg[4:0] != 5'd0)
        else $error("ROM bank register holds an unfixed bank");

    // A stalled read stage keeps its RAM data.
    a_stall_holds_ram: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(ram_rdata))
        else $error("RAM data changed under a stalled read stage");

    // Only a RAM read result carries data.
    a_data_only_ram: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != rbm_pkg::ST_RAM_READ) |->
            out_read_data_reg == '0)
        else $error("non-RAM result carries read data");

endmodule : rom_ram_bank_mapper_top
`default_nettype wire

/* dv/tb_rom_ram_bank_mapper_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_rom_ram_bank_mapper_top
// Self-checking testbench for the ROM/RAM bank mapper. A directed list covers
// the window edges, the bank fix-up, mode switching and the ignored and
// illegal accesses. Random bank-switch and RAM sessions with scattered noise
// follow. A shadow copy of the bank registers and cartridge RAM predicts
// each result, which is checked in order, field by field. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_rom_ram_bank_mapper_top;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TB_RAM_BANKS = rbm_pkg::RAM_BANKS_DFLT;
    localparam int RAM_BYTES    = TB_RAM_BANKS * rbm_pkg::RAM_BANK_BYTES;

    typedef logic [rbm_pkg::ADDR_W-1:0]     addr_t;
    typedef logic [rbm_pkg::DATA_W-1:0]     data_t;
    typedef logic [rbm_pkg::ROM_ADDR_W-1:0] rom_addr_t;

    // CPU bus address map.
    localparam addr_t ROM_FIXED_HI  = 16'h3FFF;
    localparam addr_t ROM_BANKED_LO = 16'h4000;
    localparam addr_t ROM_BANKED_HI = 16'h7FFF;
    localparam addr_t BANK_LO_SEL   = 16'h2000;
    localparam addr_t BANK_LO_END   = 16'h3FFF;
    localparam addr_t BANK_HI_SEL   = 16'h4000;
    localparam addr_t BANK_HI_END   = 16'h5FFF;
    localparam addr_t MODE_SEL      = 16'h6000;
    localparam addr_t MODE_END      = 16'h7FFF;
    localparam addr_t HOLE_LO       = 16'h8000;
    localparam addr_t HOLE_HI       = 16'h9FFF;
    localparam addr_t RAM_LO        = 16'hA000;
    localparam addr_t RAM_HI        = 16'hBFFF;
    localparam addr_t HIGH_LO       = 16'hC000;
    localparam addr_t HIGH_HI       = 16'hFFFF;
    localparam addr_t IGNORED_HI    = 16'h1FFF;

    typedef struct packed {
        logic  kind;
        addr_t address;
        data_t write_data;
    } access_t;

    typedef struct packed {
        logic [rbm_pkg::STATUS_W-1:0] status;
        rom_addr_t                    rom_address;
        data_t                        read_data;
    } result_t;

    typedef struct {
        access_t acc;
        result_t res;
    } bus_item_t;

    logic clk = 1'b0;
    logic rst_n;

    rbm_req_if req_bus ();
    rbm_rsp_if rsp_bus ();

    rom_ram_bank_mapper_top #(
        .RAM_BANKS (TB_RAM_BANKS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow mapper state.
    logic [rbm_pkg::ROM_BANK_W-1:0] mapper_rom_bank;
    logic [rbm_pkg::RAM_BANK_W-1:0] mapper_ram_bank;
    logic                           mapper_ram_mode;
    data_t                          ram_image [0:RAM_BYTES-1];

    // Stimulus and checking bookkeeping.
    bus_item_t   pending_accesses [$];
    result_t     expected_results [$];
    int unsigned written_slots [$];
    bus_item_t   cur_item;
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left;
    int          gap_left;
    int          stall_left;
    int          window_left;
    bit          rx_busy;

    // Cartridge RAM byte selected by a window address under the current bank.
    function automatic int unsigned ram_slot(addr_t addr);
        return (int'(mapper_ram_bank) % TB_RAM_BANKS) * rbm_pkg::RAM_BANK_BYTES
               + int'(addr[rbm_pkg::RAM_OFFSET_W-1:0]);
    endfunction

    // A bank number whose low five bits are zero is bumped to the next bank.
    function automatic logic [rbm_pkg::ROM_BANK_W-1:0] bank_fixup(
        logic [rbm_pkg::ROM_BANK_W-1:0] bank
    );
        return (bank[4:0] == 5'd0) ? bank + 7'd1 : bank;
    endfunction

    // Computes the result of one bus access and applies its side effects.
    function automatic result_t map_access(access_t a);
        result_t     r;
        int unsigned slot;
        r    = '0;
        slot = ram_slot(a.address);
        if (a.kind == rbm_pkg::KIND_READ)
        begin
            if (a.address <= ROM_FIXED_HI)
            begin
                r.status      = rbm_pkg::ST_ROM_READ;
                r.rom_address = rom_addr_t'(a.address);
            end
            else if (a.address <= ROM_BANKED_HI)
            begin
                r.status      = rbm_pkg::ST_ROM_READ;
                r.rom_address = {mapper_rom_bank, a.address[rbm_pkg::ROM_OFFSET_W-1:0]};
            end
            else if (a.address >= RAM_LO && a.address <= RAM_HI)
            begin
                r.status    = rbm_pkg::ST_RAM_READ;
                r.read_data = ram_image[slot];
            end
            else
            begin
                r.status = rbm_pkg::ST_ILLEGAL;
            end
        end
        else
        begin
            r.status = rbm_pkg::ST_WRITE;
            if (a.address >= BANK_LO_SEL && a.address <= BANK_LO_END)
            begin
                mapper_rom_bank = bank_fixup({mapper_rom_bank[6:5], a.write_data[4:0]});
            end
            else if (a.address >= BANK_HI_SEL && a.address <= BANK_HI_END)
            begin
                if (mapper_ram_mode)
                    mapper_ram_bank = a.write_data[1:0];
                else
                    mapper_rom_bank = bank_fixup({a.write_data[1:0], mapper_rom_bank[4:0]});
            end
            else if (a.address >= MODE_SEL && a.address <= MODE_END)
            begin
                mapper_ram_mode = a.write_data[0];
            end
            else if (a.address >= RAM_LO && a.address <= RAM_HI)
            begin
                ram_image[slot] = a.write_data;
            end
        end
        return r;
    endfunction

    // Appends one access to the stimulus together with its predicted result.
    task automatic queue_access(logic kind, addr_t addr, data_t data);
        bus_item_t item;
        item.acc = '{kind: kind, address: addr, write_data: data};
        if (kind == rbm_pkg::KIND_WRITE && addr >= RAM_LO && addr <= RAM_HI)
            written_slots.push_back(ram_slot(addr));
        item.res = map_access(item.acc);
        pending_accesses.push_back(item);
    endtask

    // Random address in an inclusive range.
    function automatic addr_t rand_addr(addr_t lo, addr_t hi);
        return addr_t'($urandom_range(lo, hi));
    endfunction

    // Random data byte.
    function automatic data_t rand_data();
        return data_t'($urandom);
    endfunction

    // Reads back a RAM byte written earlier in the current bank, or writes one.
    task automatic queue_ram_touch();
        int unsigned slot;
        bit          found;
        int          tries;
        found = 1'b0;
        slot  = 0;
        for (tries = 0; tries < 16 && !found && written_slots.size() > 0; tries++)
        begin
            slot = written_slots[$urandom_range(0, written_slots.size() - 1)];
            if (slot / rbm_pkg::RAM_BANK_BYTES == int'(mapper_ram_bank) % TB_RAM_BANKS)
                found = 1'b1;
        end
        if (found)
            queue_access(rbm_pkg::KIND_READ,
                         RAM_LO + addr_t'(slot % rbm_pkg::RAM_BANK_BYTES), rand_data());
        else
            queue_access(rbm_pkg::KIND_WRITE, rand_addr(RAM_LO, RAM_HI), rand_data());
    endtask

    // Bank data that lands on a fix-up bank one time in four.
    function automatic data_t bank_data();
        data_t d;
        d = rand_data();
        if ($urandom_range(0, 3) == 0)
            d[4:0] = 5'd0;
        return d;
    endfunction

    task automatic build_directed();
        // Window edges with the reset bank.
        queue_access(rbm_pkg::KIND_READ,  16'h0000,      8'h00);
        queue_access(rbm_pkg::KIND_READ,  ROM_FIXED_HI,  8'hFF);
        queue_access(rbm_pkg::KIND_READ,  ROM_BANKED_LO, 8'h00);
        queue_access(rbm_pkg::KIND_READ,  ROM_BANKED_HI, 8'h00);
        // Bank zero is fixed up, then the largest bank gives the top address.
        queue_access(rbm_pkg::KIND_WRITE, BANK_LO_SEL,   8'h00);
        queue_access(rbm_pkg::KIND_WRITE, BANK_LO_END,   8'hFF);
        queue_access(rbm_pkg::KIND_WRITE, BANK_HI_SEL,   8'h03);
        queue_access(rbm_pkg::KIND_READ,  ROM_BANKED_HI, 8'h00);
        queue_access(rbm_pkg::KIND_WRITE, BANK_LO_SEL,   8'h20);
        queue_access(rbm_pkg::KIND_READ,  ROM_BANKED_LO, 8'h00);
        queue_access(rbm_pkg::KIND_WRITE, BANK_HI_END,   8'h02);
        // RAM banking mode, last RAM bank, both edges of the RAM window.
        queue_access(rbm_pkg::KIND_WRITE, MODE_SEL,      8'h01);
        queue_access(rbm_pkg::KIND_WRITE, BANK_HI_SEL,   8'h03);
        queue_access(rbm_pkg::KIND_WRITE, RAM_LO,        8'hA5);
        queue_access(rbm_pkg::KIND_WRITE, RAM_HI,        8'h5A);
        queue_access(rbm_pkg::KIND_READ,  RAM_LO,        8'hFF);
        queue_access(rbm_pkg::KIND_READ,  RAM_HI,        8'h00);
        // Back to ROM banking mode: the RAM bank stays where it was.
        queue_access(rbm_pkg::KIND_WRITE, MODE_END,      8'hFE);
        queue_access(rbm_pkg::KIND_WRITE, BANK_HI_SEL,   8'h00);
        queue_access(rbm_pkg::KIND_READ,  RAM_HI,        8'h00);
        // Illegal reads and ignored writes that change nothing.
        queue_access(rbm_pkg::KIND_READ,  HOLE_LO,       8'h00);
        queue_access(rbm_pkg::KIND_READ,  HIGH_LO,       8'hFF);
        queue_access(rbm_pkg::KIND_READ,  HIGH_HI,       8'h00);
        queue_access(rbm_pkg::KIND_WRITE, 16'h0000,      8'hFF);
        queue_access(rbm_pkg::KIND_WRITE, HOLE_HI,       8'hFF);
        queue_access(rbm_pkg::KIND_WRITE, HIGH_HI,       8'h00);
    endtask

    task automatic build_random();
        int target;
        int n;
        int i;
        target = pending_accesses.size() + RANDOM_ITEMS;
        while (pending_accesses.size() < target)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // Bank switch followed by reads from the switched window.
                    queue_access(rbm_pkg::KIND_WRITE, rand_addr(BANK_LO_SEL, BANK_LO_END),
                                 bank_data());
                    if ($urandom_range(0, 1) == 0)
                        queue_access(rbm_pkg::KIND_WRITE,
                                     rand_addr(BANK_HI_SEL, BANK_HI_END), rand_data());
                    n = $urandom_range(1, 4);
                    for (i = 0; i < n; i++)
                        queue_access(rbm_pkg::KIND_READ,
                                     rand_addr(ROM_BANKED_LO, ROM_BANKED_HI), rand_data());
                    if ($urandom_range(0, 2) == 0)
                        queue_access(rbm_pkg::KIND_READ, rand_addr(16'h0000, ROM_FIXED_HI),
                                     rand_data());
                end
                2, 3, 4:
                begin
                    // RAM session: mode and bank selection, then writes and reads.
                    if ($urandom_range(0, 1) == 0)
                        queue_access(rbm_pkg::KIND_WRITE, rand_addr(MODE_SEL, MODE_END),
                                     ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                                                   8'($urandom) | 8'h01);
                    if ($urandom_range(0, 1) == 0)
                        queue_access(rbm_pkg::KIND_WRITE,
                                     rand_addr(BANK_HI_SEL, BANK_HI_END), rand_data());
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            queue_access(rbm_pkg::KIND_WRITE, rand_addr(RAM_LO, RAM_HI),
                                         rand_data());
                        else
                            queue_ram_touch();
                    end
                end
                5:
                    queue_access(rbm_pkg::KIND_WRITE, rand_addr(MODE_SEL, MODE_END),
                                 rand_data());
                6:
                    queue_access(rbm_pkg::KIND_READ, rand_addr(16'h0000, ROM_BANKED_HI),
                                 rand_data());
                7:
                begin
                    // Read outside both windows.
                    if ($urandom_range(0, 1) == 0)
                        queue_access(rbm_pkg::KIND_READ, rand_addr(HOLE_LO, HOLE_HI),
                                     rand_data());
                    else
                        queue_access(rbm_pkg::KIND_READ, rand_addr(HIGH_LO, HIGH_HI),
                                     rand_data());
                end
                8:
                begin
                    // Write to a region without registers or RAM.
                    case ($urandom_range(0, 2))
                        0: queue_access(rbm_pkg::KIND_WRITE, rand_addr(16'h0000, IGNORED_HI),
                                        rand_data());
                        1: queue_access(rbm_pkg::KIND_WRITE, rand_addr(HOLE_LO, HOLE_HI),
                                        rand_data());
                        default:
                            queue_access(rbm_pkg::KIND_WRITE, rand_addr(HIGH_LO, HIGH_HI),
                                         rand_data());
                    endcase
                end
                default:
                    queue_ram_touch();
            endcase
        end
    endtask

    // Request driver: bursts of items separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        logic load_item;
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                expected_results.push_back(cur_item.res);
            if (!req_bus.valid || req_bus.ready)
            begin
                load_item = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_accesses.size() > 0)
                begin
                    cur_item  = pending_accesses.pop_front();
                    load_item = 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                req_bus.valid <= load_item;
                if (load_item)
                begin
                    req_bus.kind       <= cur_item.acc.kind;
                    req_bus.address    <= cur_item.acc.address;
                    req_bus.write_data <= cur_item.acc.write_data;
                end
            end
        end
    end

    // Result monitor: in-order comparison and a windowed stall pattern.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        result_t want;
        logic    next_ready;
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left  = 0;
            window_left = 0;
            rx_busy     = 1'b0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, rsp_bus.status);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_bus.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, rsp_bus.status);
                        error_count++;
                    end
                    if (rsp_bus.rom_address !== want.rom_address)
                    begin
                        $display("%0t: rom_address mismatch, expected 0x%06h, actual 0x%06h",
                                 $time, want.rom_address, rsp_bus.rom_address);
                        error_count++;
                    end
                    if (rsp_bus.read_data !== want.read_data)
                    begin
                        $display("%0t: read_data mismatch, expected 0x%02h, actual 0x%02h",
                                 $time, want.read_data, rsp_bus.read_data);
                        error_count++;
                    end
                end
            end
            // Alternate calm windows with windows of short random stalls.
            if (window_left == 0)
            begin
                window_left = $urandom_range(32, 200);
                rx_busy     = ($urandom_range(0, 2) != 0);
            end
            else
            begin
                window_left--;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else if (rx_busy && $urandom_range(0, 2) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
            end
            rsp_bus.ready <= next_ready;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Reset, stimulus build and end of run.
    initial
    begin
        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.kind       = rbm_pkg::KIND_READ;
        req_bus.address    = '0;
        req_bus.write_data = '0;
        rsp_bus.ready      = 1'b0;
        mapper_rom_bank    = rbm_pkg::ROM_BANK_RESET;
        mapper_ram_bank    = '0;
        mapper_ram_mode    = 1'b0;
        build_directed();
        build_random();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_accesses.size() != 0 || req_bus.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule : tb_rom_ram_bank_mapper_top
`default_nettype wire
